/* src/shell_line_tokenizer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shell line tokenizer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_TOKENIZER_TOP_MACROS_SVH
`define SHELL_LINE_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication.
`define STL_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and character constants of the shell line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int MODE_W = 3;

    // Lexer modes
    localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORD_EMPTY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WORD       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SQ_EMPTY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DQ_EMPTY   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SQ         = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DQ         = 3'd6;
    localparam logic [MODE_W-1:0] MODE_REDIR      = 3'd7;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REDIR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIPE  = 2'd2;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int PUSH_W     = 2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] held_char;
        logic [KIND_W-1:0] held_kind;
        logic              held_valid;
        logic              redir_doubled;
    } stl_state_t;

    localparam stl_state_t STATE_RESET = '{
        mode:          MODE_IDLE,
        held_char:     '0,
        held_kind:     KIND_WORD,
        held_valid:    1'b0,
        redir_doubled: 1'b0
    };

    typedef struct packed {
        logic [CHAR_W-1:0] token_char;
        logic [KIND_W-1:0] token_kind;
        logic              token_end;
        logic              line_done;
    } stl_tok_t;

    // Up to two results per item: the released held character, then the
    // line-end flush.
    typedef struct packed {
        logic     first_valid;
        stl_tok_t first;
        logic     flush_valid;
        stl_tok_t flush;
    } stl_emit_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_operator(input logic [CHAR_W-1:0] c);
        return (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT);
    endfunction

endpackage

`default_nettype wire

/* src/stl_if.sv */
// ----------------------------------------------------------------------------
// stl_if
// Valid/ready channels for input characters and output token characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface stl_char_if
    import stl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface stl_tok_if
    import stl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] token_char;
    logic [KIND_W-1:0] token_kind;
    logic              token_end;
    logic              line_done;

    modport source (output valid, output token_char, output token_kind,
                    output token_end, output line_done, input ready);
    modport sink   (input valid, input token_char, input token_kind,
                    input token_end, input line_done, output ready);
endinterface

`default_nettype wire

/* src/shell_line_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// shell_line_tokenizer_top
// Lexes a command line one character per item into token characters.
// ----------------------------------------------------------------------------
// Results: the results of an accepted item are registered in the result
//   queue, which drives tokens; they leave it in order.
// Throughput: one character per cycle while the queue has room for two
//   results; the single output port drains one result per cycle while ready.
// Reset: rst_n clears the lexer state and empties the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_line_tokenizer_top
    import stl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    stl_char_if.sink  chars,
    stl_tok_if.source tokens
);

    // Lexer state: mode plus the one held-back character.
    stl_state_t        state_reg;
    stl_state_t        state_next;
    stl_state_t        core_state;
    stl_emit_t         core_emit;
    logic              accept;
    logic              room;
    logic [PUSH_W-1:0] push_n;
    stl_tok_t          push0;
    stl_tok_t          push1;

    // Accept whenever the queue can absorb the worst case of two results.
    assign chars.ready = room;
    assign accept      = chars.valid && chars.ready;

    stl_lex_core u_core (
        .state      (state_reg),
        .char_in    (chars.char_in),
        .line_end   (chars.line_end),
        .state_next (core_state),
        .emit       (core_emit)
    );

    assign state_next = accept ? core_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pack the results in order: released held character, then flush.
    always_comb
    begin
        push0  = core_emit.first_valid ? core_emit.first : core_emit.flush;
        push1  = core_emit.flush;
        push_n = accept ? (PUSH_W'(core_emit.first_valid) + PUSH_W'(core_emit.flush_valid))
                        : '0;
    end

    stl_out_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .push0  (push0),
        .push1  (push1),
        .room   (room),
        .tokens (tokens)
    );

`include "shell_line_tokenizer_top_macros.svh"

    // A line end leaves the lexer exactly as reset does.
    `STL_ASSERT_NEXT(a_line_reset, accept && chars.line_end, state_reg == STATE_RESET, "state not cleared after line end")
    // An open redirect always holds its operator character.
    `STL_ASSERT_HOLD(a_redir_held, state_reg.mode == MODE_REDIR, state_reg.held_valid && state_reg.held_kind == KIND_REDIR, "redirect mode without held operator")

endmodule

`default_nettype wire

/* src/stl_lex_core.sv */
// ----------------------------------------------------------------------------
// stl_lex_core
// Next-state and result logic of the lexer for one input character.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_lex_core
    import stl_pkg::*;
(
    input  stl_state_t        state,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              line_end,
    output stl_state_t        state_next,
    output stl_emit_t         emit
);

    stl_state_t        n;
    logic              take;
    logic              brk;
    logic [KIND_W-1:0] kind;
    logic              run_idle;

    always_comb
    begin
        n        = state;
        take     = 1'b0;
        brk      = 1'b0;
        kind     = KIND_WORD;
        run_idle = 1'b0;

        unique case (state.mode)
            MODE_IDLE:
            begin
                run_idle = 1'b1;
            end
            MODE_WORD_EMPTY, MODE_WORD:
            begin
                if (is_space(char_in))
                begin
                    n.mode = MODE_IDLE;
                end
                else if (is_operator(char_in))
                begin
                    n.mode   = MODE_IDLE;
                    run_idle = 1'b1;
                end
                else if (char_in == CH_SQ)
                begin
                    n.mode = (state.mode == MODE_WORD_EMPTY) ? MODE_SQ_EMPTY : MODE_SQ;
                end
                else if (char_in == CH_DQ)
                begin
                    n.mode = (state.mode == MODE_WORD_EMPTY) ? MODE_DQ_EMPTY : MODE_DQ;
                end
                else
                begin
                    take   = 1'b1;
                    brk    = (state.mode == MODE_WORD_EMPTY);
                    n.mode = MODE_WORD;
                end
            end
            MODE_SQ_EMPTY, MODE_DQ_EMPTY:
            begin
                if (char_in == ((state.mode == MODE_SQ_EMPTY) ? CH_SQ : CH_DQ))
                begin
                    n.mode = MODE_WORD_EMPTY;
                end
                else
                begin
                    take   = 1'b1;
                    brk    = 1'b1;
                    n.mode = (state.mode == MODE_SQ_EMPTY) ? MODE_SQ : MODE_DQ;
                end
            end
            MODE_SQ, MODE_DQ:
            begin
                if (char_in == ((state.mode == MODE_SQ) ? CH_SQ : CH_DQ))
                begin
                    n.mode = MODE_WORD;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            MODE_REDIR:
            begin
                if (state.held_valid && (char_in == state.held_char) && !state.redir_doubled)
                begin
                    take            = 1'b1;
                    kind            = KIND_REDIR;
                    n.redir_doubled = 1'b1;
                end
                else
                begin
                    n.mode   = MODE_IDLE;
                    run_idle = 1'b1;
                end
            end
        endcase

        // Character seen between tokens
        if (run_idle && !is_space(char_in))
        begin
            priority if (char_in == CH_PIPE)
            begin
                take = 1'b1;
                brk  = 1'b1;
                kind = KIND_PIPE;
            end
            else if ((char_in == CH_LT) || (char_in == CH_GT))
            begin
                take            = 1'b1;
                brk             = 1'b1;
                kind            = KIND_REDIR;
                n.redir_doubled = 1'b0;
                n.mode          = MODE_REDIR;
            end
            else if (char_in == CH_SQ)
            begin
                n.mode = MODE_SQ_EMPTY;
            end
            else if (char_in == CH_DQ)
            begin
                n.mode = MODE_DQ_EMPTY;
            end
            else
            begin
                take   = 1'b1;
                brk    = 1'b1;
                kind   = KIND_WORD;
                n.mode = MODE_WORD;
            end
        end

        // Release the held character when a new one takes its place
        emit.first_valid      = take && state.held_valid;
        emit.first.token_char = state.held_char;
        emit.first.token_kind = state.held_kind;
        emit.first.token_end  = brk;
        emit.first.line_done  = 1'b0;

        if (take)
        begin
            n.held_char  = char_in;
            n.held_kind  = kind;
            n.held_valid = 1'b1;
        end

        // Flush at line end and return to reset
        emit.flush_valid      = line_end && n.held_valid;
        emit.flush.token_char = n.held_char;
        emit.flush.token_kind = n.held_kind;
        emit.flush.token_end  = 1'b1;
        emit.flush.line_done  = 1'b1;

        if (line_end)
        begin
            n = STATE_RESET;
        end

        state_next = n;
    end

endmodule

`default_nettype wire

/* src/stl_out_fifo.sv */
// ----------------------------------------------------------------------------
// stl_out_fifo
// Small result queue taking up to two items per cycle, one out per cycle while tokens.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_out_fifo
    import stl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PUSH_W-1:0] push_n,
    input  stl_tok_t          push0,
    input  stl_tok_t          push1,
    output logic              room,
    stl_tok_if.source         tokens
);

    stl_tok_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop  = tokens.valid && tokens.ready;
    assign room = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != '0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == PUSH_W'(2))
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    assign tokens.valid      = (count_reg != '0);
    assign tokens.token_char = mem_reg[rd_ptr_reg].token_char;
    assign tokens.token_kind = mem_reg[rd_ptr_reg].token_kind;
    assign tokens.token_end  = mem_reg[rd_ptr_reg].token_end;
    assign tokens.line_done  = mem_reg[rd_ptr_reg].line_done;

`include "shell_line_tokenizer_top_macros.svh"

    `STL_ASSERT_HOLD(a_fifo_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "fifo count over depth")
    `STL_ASSERT_HOLD(a_fifo_push_room, push_n != '0, count_reg <= CNT_W'(FIFO_DEPTH - 2), "fifo push without room")

endmodule

`default_nettype wire
